[src/vrts_pkg.sv]
// shared types and constants for the valid run table sorter
// no dependencies; imported by the controller, datapath and top level
package vrts_pkg;

    // table geometry and field widths
    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 16;
    localparam int TAG_BITS      = 16;
    localparam int SLOT_BITS     = 4;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);
    localparam logic [SLOT_BITS:0]  SLOT_LIMIT = (SLOT_BITS + 1)'(TABLE_ENTRIES);

    // request command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SORT  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic                wr_en;
        logic                sort_en;
        logic                odd_phase;
        logic                load_en;
        logic [IDX_BITS-1:0] idx;
    } t_dp_cmd;

endpackage

[src/vrts_ctrl.sv]
// controller: accepts requests, sequences the sort passes and the emission
// depends on vrts_pkg
module vrts_ctrl
    import vrts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_stall,
    input  logic    i_command,
    output logic    o_res_valid,
    input  logic    i_res_stall,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SORT = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [IDX_BITS-1:0] r_cnt, n_cnt;
    logic                r_res_valid, n_res_valid;
    logic                accept;
    logic                load;

    // handshake decode
    assign o_req_stall = (r_state != S_IDLE);
    assign accept      = i_req_valid && !o_req_stall;
    assign load        = (r_state == S_EMIT) && (!r_res_valid || !i_res_stall);
    assign o_res_valid = r_res_valid;

    // commands to the datapath
    always_comb begin
        o_cmd.wr_en     = accept && (i_command == CMD_WRITE);
        o_cmd.sort_en   = (r_state == S_SORT);
        o_cmd.odd_phase = r_cnt[0];
        o_cmd.load_en   = load;
        o_cmd.idx       = r_cnt;
    end

    // next state: one sort pass per cycle, then one entry per unstalled cycle
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_SORT)) begin
                    n_state = S_SORT;
                    n_cnt   = '0;
                end
            end
            S_SORT: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                if (load) begin
                    if (r_cnt == LAST_IDX) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        n_res_valid = r_res_valid;
        if (load) begin
            n_res_valid = 1'b1;
        end else if (!i_res_stall) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

[src/vrts_datapath.sv]
// datapath: entry table, odd-even compare-swap row and output register
// depends on vrts_pkg
module vrts_datapath
    import vrts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [SLOT_BITS-1:0] i_slot,
    input  logic                 i_entry_is_valid,
    input  logic [KEY_BITS-1:0]  i_sort_key,
    input  logic [TAG_BITS-1:0]  i_entry_tag,
    output logic                 o_out_valid,
    output logic [KEY_BITS-1:0]  o_out_key,
    output logic [TAG_BITS-1:0]  o_out_tag,
    output logic                 o_last_entry
);

    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [KEY_BITS-1:0]      r_key [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]      n_key [TABLE_ENTRIES];
    logic [TAG_BITS-1:0]      r_tag [TABLE_ENTRIES];
    logic [TAG_BITS-1:0]      n_tag [TABLE_ENTRIES];
    logic                     r_out_valid;
    logic [KEY_BITS-1:0]      r_out_key;
    logic [TAG_BITS-1:0]      r_out_tag;
    logic                     r_out_last;
    logic                     slot_in_range;
    logic [IDX_BITS-1:0]      wr_idx;

    assign slot_in_range = ({1'b0, i_slot} < SLOT_LIMIT);
    assign wr_idx        = i_slot[IDX_BITS-1:0];

    // table update: entry write or one transposition pass over neighbor pairs
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_cmd.wr_en) begin
            if (slot_in_range) begin
                n_valid[wr_idx] = i_entry_is_valid;
                n_key[wr_idx]   = i_sort_key;
                n_tag[wr_idx]   = i_entry_tag;
            end
        end else if (i_cmd.sort_en) begin
            for (int j = 0; j < TABLE_ENTRIES - 1; j++) begin
                // swap only inside a valid run, strictly greater keeps it stable
                if (((j % 2) == 1) == i_cmd.odd_phase && r_valid[j] && r_valid[j+1]
                    && (r_key[j] > r_key[j+1])) begin
                    n_key[j]   = r_key[j+1];
                    n_key[j+1] = r_key[j];
                    n_tag[j]   = r_tag[j+1];
                    n_tag[j+1] = r_tag[j];
                end
            end
        end
    end

    // valid bits cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key and tag storage
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    // output register, invalid entries show zero key and tag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_out_valid <= r_valid[i_cmd.idx];
            r_out_key   <= r_valid[i_cmd.idx] ? r_key[i_cmd.idx] : '0;
            r_out_tag   <= r_valid[i_cmd.idx] ? r_tag[i_cmd.idx] : '0;
            r_out_last  <= (i_cmd.idx == LAST_IDX);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_key    = r_out_key;
    assign o_out_tag    = r_out_tag;
    assign o_last_entry = r_out_last;

endmodule

[src/valid_run_table_sorter_core.sv]
// Valid run table sorter, top level: controller plus datapath.
// A write request updates the table and the next request can be taken on the next cycle.
// A sort request makes one sort pass per table entry, then emits one entry per cycle
// from the output register (16 results) while the output is not stalled.
// The first result is loaded after the last sort pass; output stall can delay it.
// Synchronous active-low reset marks every table entry invalid and empties the output.
module valid_run_table_sorter_core
    import vrts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_stall,
    input  logic                 i_command,
    input  logic [SLOT_BITS-1:0] i_slot,
    input  logic                 i_entry_is_valid,
    input  logic [KEY_BITS-1:0]  i_sort_key,
    input  logic [TAG_BITS-1:0]  i_entry_tag,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output logic                 o_out_valid,
    output logic [KEY_BITS-1:0]  o_out_key,
    output logic [TAG_BITS-1:0]  o_out_tag,
    output logic                 o_last_entry
);

    t_dp_cmd dp_cmd;

    // sequencing
    vrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_command   (i_command),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_cmd       (dp_cmd)
    );

    // table storage and sorting
    vrts_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_slot           (i_slot),
        .i_entry_is_valid (i_entry_is_valid),
        .i_sort_key       (i_sort_key),
        .i_entry_tag      (i_entry_tag),
        .o_out_valid      (o_out_valid),
        .o_out_key        (o_out_key),
        .o_out_tag        (o_out_tag),
        .o_last_entry     (o_last_entry)
    );

endmodule

[tb/valid_run_table_sorter_core_test.sv]
// self-checking testbench for valid_run_table_sorter_core: directed table, then random requests
// depends on vrts_pkg (src/vrts_pkg.sv) and the valid_run_table_sorter_core top level
module valid_run_table_sorter_core_test;
    import vrts_pkg::*;

    localparam int RANDOM_ITEMS  = 150;
    localparam int DIRECTED_ROWS = 17;
    localparam int HOLD_CYCLES   = 150;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 40;

    // one request as offered to the block
    typedef struct packed {
        logic                 cmd;
        logic [SLOT_BITS-1:0] slot;
        logic                 ent_valid;
        logic [KEY_BITS-1:0]  key;
        logic [TAG_BITS-1:0]  tag;
        logic                 blank_table;
    } t_stim_row;

    // one emitted table entry
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic                last;
    } t_table_entry;

    logic                 i_clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_command;
    logic [SLOT_BITS-1:0] req_slot;
    logic                 req_ent_valid;
    logic [KEY_BITS-1:0]  req_key;
    logic [TAG_BITS-1:0]  req_tag;
    logic                 req_blank;
    logic                 res_stall;
    logic                 o_req_stall;
    logic                 o_res_valid;
    logic                 o_out_valid;
    logic [KEY_BITS-1:0]  o_out_key;
    logic [TAG_BITS-1:0]  o_out_tag;
    logic                 o_last_entry;

    // shadow copy of the table and the entries still to be emitted
    logic                 table_valid [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]  table_key   [TABLE_ENTRIES];
    logic [TAG_BITS-1:0]  table_tag   [TABLE_ENTRIES];
    t_table_entry         emitted_entries_due[$];

    int  errors          = 0;
    int  idle_cycles     = 0;
    int  writes_taken    = 0;
    int  sorts_taken     = 0;
    int  entries_checked = 0;
    bit  idle_enabled    = 1'b1;
    bit  hold_results    = 1'b0;

    t_stim_row directed_rows [DIRECTED_ROWS];

    valid_run_table_sorter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .o_req_stall      (o_req_stall),
        .i_command        (req_command),
        .i_slot           (req_slot),
        .i_entry_is_valid (req_ent_valid),
        .i_sort_key       (req_key),
        .i_entry_tag      (req_tag),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (res_stall),
        .o_out_valid      (o_out_valid),
        .o_out_key        (o_out_key),
        .o_out_tag        (o_out_tag),
        .o_last_entry     (o_last_entry)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // gnome sort over the shadow table; invalid entries act as barriers
    task automatic sort_table_runs();
        int                  pos;
        logic [KEY_BITS-1:0] k;
        logic [TAG_BITS-1:0] t;
        pos = 1;
        while (pos < TABLE_ENTRIES) begin
            if (table_valid[pos-1] && table_valid[pos] &&
                table_key[pos-1] > table_key[pos]) begin
                k = table_key[pos-1];
                t = table_tag[pos-1];
                table_key[pos-1] = table_key[pos];
                table_tag[pos-1] = table_tag[pos];
                table_key[pos]   = k;
                table_tag[pos]   = t;
                pos = (pos > 1) ? pos - 1 : 1;
            end else begin
                pos++;
            end
        end
    endtask

    // offer one request and wait until the block takes it
    task automatic send_request(input t_stim_row row);
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_valid     <= 1'b1;
        req_command   <= row.cmd;
        req_slot      <= row.slot;
        req_ent_valid <= row.ent_valid;
        req_key       <= row.key;
        req_tag       <= row.tag;
        req_blank     <= row.blank_table;
        @(posedge i_clk);
        while (!(req_valid && !o_req_stall)) @(posedge i_clk);
    endtask

    // wait for every emitted entry that is due
    task automatic wait_table_drained();
        @(posedge i_clk);
        while (emitted_entries_due.size() != 0) @(posedge i_clk);
    endtask

    // check emitted entries, then update the shadow table with the accepted request
    always @(posedge i_clk) begin
        t_table_entry got;
        t_table_entry want;
        bit           moved;
        moved = 1'b0;
        if (rst_n) begin
            if (o_res_valid && !res_stall) begin
                moved = 1'b1;
                got   = '{o_out_valid, o_out_key, o_out_tag, o_last_entry};
                if (emitted_entries_due.size() == 0) begin
                    $display("%0t: unexpected entry valid=%b key=%h tag=%h last=%b",
                             $time, got.valid, got.key, got.tag, got.last);
                    errors++;
                end else begin
                    want = emitted_entries_due.pop_front();
                    entries_checked++;
                    if (got.valid !== want.valid) begin
                        $display("%0t: out_valid expected %b got %b", $time, want.valid,
                                 got.valid);
                        errors++;
                    end
                    if (got.key !== want.key) begin
                        $display("%0t: out_key expected %h got %h", $time, want.key, got.key);
                        errors++;
                    end
                    if (got.tag !== want.tag) begin
                        $display("%0t: out_tag expected %h got %h", $time, want.tag, got.tag);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_entry expected %b got %b", $time, want.last,
                                 got.last);
                        errors++;
                    end
                end
            end
            if (req_valid && !o_req_stall) begin
                moved = 1'b1;
                if (req_command == CMD_WRITE) begin
                    writes_taken++;
                    table_valid[req_slot] = req_ent_valid;
                    table_key[req_slot]   = req_key;
                    table_tag[req_slot]   = req_tag;
                end else begin
                    sorts_taken++;
                    sort_table_runs();
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (req_blank) begin
                            // empty table: every entry invalid and zeroed
                            emitted_entries_due.push_back(
                                '{1'b0, '0, '0, (i == TABLE_ENTRIES - 1)});
                        end else begin
                            emitted_entries_due.push_back('{
                                table_valid[i],
                                table_valid[i] ? table_key[i] : '0,
                                table_valid[i] ? table_tag[i] : '0,
                                (i == TABLE_ENTRIES - 1)});
                        end
                    end
                end
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    // result side: random stall bursts plus one long hold-off
    initial begin
        res_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                res_stall    <= 1'b0;
                hold_results = 1'b0;
            end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                res_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("valid_run_table_sorter_core test failed");
        $finish;
    end

    // stimulus
    initial begin
        t_stim_row row;
        int        burst_sorts;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            table_valid[i] = 1'b0;
            table_key[i]   = '0;
            table_tag[i]   = '0;
        end
        rst_n         <= 1'b0;
        req_valid     <= 1'b0;
        req_command   <= CMD_WRITE;
        req_slot      <= '0;
        req_ent_valid <= 1'b0;
        req_key       <= '0;
        req_tag       <= '0;
        req_blank     <= 1'b0;

        // directed: empty table, extremes, barrier, equal keys, ignored sort fields
        directed_rows = '{
            '{CMD_SORT,  4'hF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1},
            '{CMD_WRITE, 4'h0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0},
            '{CMD_WRITE, 4'h1, 1'b1, 16'h0000, 16'h0000, 1'b0},
            '{CMD_WRITE, 4'h2, 1'b1, 16'h8000, 16'h1234, 1'b0},
            '{CMD_WRITE, 4'h3, 1'b0, 16'hABCD, 16'h5555, 1'b0},
            '{CMD_WRITE, 4'h4, 1'b1, 16'h0005, 16'h0001, 1'b0},
            '{CMD_WRITE, 4'h5, 1'b1, 16'h0005, 16'h0002, 1'b0},
            '{CMD_WRITE, 4'h6, 1'b1, 16'h0003, 16'h0003, 1'b0},
            '{CMD_WRITE, 4'hE, 1'b1, 16'hFFFF, 16'h0000, 1'b0},
            '{CMD_WRITE, 4'hF, 1'b1, 16'h7FFF, 16'h8000, 1'b0},
            '{CMD_SORT,  4'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
            '{CMD_WRITE, 4'h3, 1'b1, 16'h0001, 16'hAAAA, 1'b0},
            '{CMD_SORT,  4'h7, 1'b0, 16'h1234, 16'h4321, 1'b0},
            '{CMD_WRITE, 4'h0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0},
            '{CMD_WRITE, 4'hF, 1'b0, 16'h0000, 16'h0000, 1'b0},
            '{CMD_SORT,  4'h5, 1'b1, 16'h5A5A, 16'hA5A5, 1'b0},
            '{CMD_SORT,  4'hA, 1'b0, 16'hFFFF, 16'h0000, 1'b0}
        };

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int d = 0; d < DIRECTED_ROWS; d++) send_request(directed_rows[d]);

        // random: mostly valid writes with clustered keys, sorts now and then
        burst_sorts = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 40) begin
                // results held back while sorts keep coming, so the block backs up
                hold_results = 1'b1;
                burst_sorts  = 4;
            end
            if (n == 90) begin
                req_valid <= 1'b0;
                wait_table_drained();
            end
            if (n == RANDOM_ITEMS - 30) idle_enabled = 1'b0;
            row.blank_table = 1'b0;
            row.slot        = SLOT_BITS'($urandom_range(0, 15));
            row.ent_valid   = ($urandom_range(0, 7) != 0);
            row.tag         = TAG_BITS'($urandom);
            case ($urandom_range(0, 7))
                0:       row.key = '0;
                1:       row.key = '1;
                2, 3:    row.key = KEY_BITS'($urandom_range(0, 7));
                default: row.key = KEY_BITS'($urandom);
            endcase
            if (burst_sorts > 0 || n == RANDOM_ITEMS - 1 || $urandom_range(0, 6) == 0) begin
                row.cmd = CMD_SORT;
                if (burst_sorts > 0) burst_sorts--;
            end else begin
                row.cmd = CMD_WRITE;
            end
            send_request(row);
        end

        req_valid <= 1'b0;
        wait_table_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d writes and %0d sorts, %0d emitted entries checked",
                 writes_taken, sorts_taken, entries_checked);
        $display("with barriers, duplicate keys, output back-pressure and request gaps");
        if (errors == 0) begin
            $display("valid_run_table_sorter_core test passed");
        end else begin
            $display("valid_run_table_sorter_core test failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/vrts_pkg.sv
src/vrts_ctrl.sv
src/vrts_datapath.sv
src/valid_run_table_sorter_core.sv
tb/valid_run_table_sorter_core_test.sv
